@@ sv/hsda_pkg.sv @@
// ----------------------------------------------------------------------------
// hsda_pkg
// Shared types and constants for the sparse delta histogram accumulator.
// ----------------------------------------------------------------------------
package hsda_pkg;

    localparam int Bins         = 256;
    localparam int CounterWidth = 32;
    localparam int AddrW        = (Bins > 1) ? $clog2(Bins) : 1;

    typedef logic [AddrW-1:0]        addr_t;
    typedef logic [CounterWidth-1:0] cnt_t;
    typedef logic [31:0]             bin_value_t;

    localparam logic [2:0] CmdHeader   = 3'd0;
    localparam logic [2:0] CmdBinAdd   = 3'd1;
    localparam logic [2:0] CmdTupleAdd = 3'd2;
    localparam logic [2:0] CmdMerge    = 3'd3;
    localparam logic [2:0] CmdRead     = 3'd4;
    localparam logic [2:0] CmdClear    = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic        keyframe_in;
        logic [63:0] tuple_delta;
        logic [63:0] interval_in;
        logic [7:0]  bin_index;
        logic [31:0] counter_delta;
    } item_t;

    typedef struct packed {
        logic [31:0] bin_value;
        logic [63:0] tuple_count;
        logic        keyframe_out;
        logic [63:0] interval_out;
        logic        index_error;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // take the input word and launch the counter read
        logic exec;     // write back, update scalars, load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic result_full;
    } dp_status_t;

endpackage

@@ sv/hsda_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsda_ctrl
// Two-state sequencer: accept a word, then execute it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module hsda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   result_stall,
    input  hsda_pkg::dp_status_t   status,
    output hsda_pkg::ctrl_cmd_t    cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StExec = 1'b1;

    logic state_reg;
    logic state_next;

    assign item_stall  = (state_reg != StIdle);
    assign cmd.capture = item_valid && (state_reg == StIdle);
    // hold in execute while the previous result still waits downstream
    assign cmd.exec    = (state_reg == StExec) && (!status.result_full || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            StIdle:
            begin
                if (cmd.capture)
                begin
                    state_next = StExec;
                end
            end
            StExec:
            begin
                if (cmd.exec)
                begin
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.exec))
        else $error("capture and execute in the same cycle");

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == StExec) && item_stall)
        else $error("accepted word not followed by execute");

    a_exec_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == StIdle))
        else $error("execute did not return to idle");

endmodule

@@ sv/hsda_datapath.sv @@
// ----------------------------------------------------------------------------
// hsda_datapath
// Counter memory with per-entry valid bits, scalar bookkeeping registers and
// the result register.
// ----------------------------------------------------------------------------
module hsda_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hsda_pkg::ctrl_cmd_t    cmd,
    output hsda_pkg::dp_status_t   status,
    input  hsda_pkg::item_t        item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hsda_pkg::result_t      result
);

    hsda_pkg::cnt_t mem [hsda_pkg::Bins];

    logic [hsda_pkg::Bins-1:0] valid_reg;

    hsda_pkg::item_t   item_reg;
    hsda_pkg::cnt_t    rd_data_reg;
    logic              rd_valid_reg;

    logic [63:0]       tuple_reg;
    logic [63:0]       tuple_next;
    logic              key_reg;
    logic              key_next;
    logic [63:0]       interval_reg;
    logic [63:0]       interval_next;

    logic              result_valid_reg;
    hsda_pkg::result_t result_reg;
    hsda_pkg::result_t result_next;

    hsda_pkg::addr_t   rd_addr;
    hsda_pkg::addr_t   wr_addr;
    logic              in_range;
    logic              wr_en;
    logic              clear_en;
    hsda_pkg::cnt_t    cur;
    hsda_pkg::cnt_t    sum;
    hsda_pkg::cnt_t    value;

    assign rd_addr  = hsda_pkg::addr_t'(item.bin_index);
    assign wr_addr  = hsda_pkg::addr_t'(item_reg.bin_index);
    assign in_range = 32'(item_reg.bin_index) < 32'(hsda_pkg::Bins);
    assign cur      = rd_valid_reg ? rd_data_reg : '0;
    assign sum      = hsda_pkg::cnt_t'(cur + hsda_pkg::cnt_t'(item_reg.counter_delta));
    assign wr_en    = cmd.exec && in_range && (item_reg.command == hsda_pkg::CmdBinAdd);
    assign clear_en = cmd.exec && (item_reg.command == hsda_pkg::CmdClear);

    always_comb
    begin
        tuple_next    = tuple_reg;
        key_next      = key_reg;
        interval_next = interval_reg;
        value         = in_range ? cur : '0;
        case (item_reg.command)
            hsda_pkg::CmdHeader:
            begin
                tuple_next    = tuple_reg + item_reg.tuple_delta;
                key_next      = item_reg.keyframe_in;
                interval_next = item_reg.interval_in;
            end
            hsda_pkg::CmdBinAdd:
            begin
                if (in_range)
                begin
                    value = sum;
                end
            end
            hsda_pkg::CmdTupleAdd:
            begin
                tuple_next = tuple_reg + item_reg.tuple_delta;
            end
            hsda_pkg::CmdMerge:
            begin
                key_next = key_reg | item_reg.keyframe_in;
                if (item_reg.interval_in > interval_reg)
                begin
                    interval_next = item_reg.interval_in;
                end
            end
            hsda_pkg::CmdClear:
            begin
                tuple_next    = '0;
                key_next      = 1'b0;
                interval_next = '0;
                value         = '0;
            end
            default:
            begin
            end
        endcase

        result_next.bin_value    = hsda_pkg::bin_value_t'(value);
        result_next.tuple_count  = tuple_next;
        result_next.keyframe_out = key_next;
        result_next.interval_out = interval_next;
        result_next.index_error  = !in_range &&
            ((item_reg.command == hsda_pkg::CmdBinAdd) ||
             (item_reg.command == hsda_pkg::CmdRead));
    end

    // memory and captured operands
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg     <= item;
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= sum;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            tuple_reg        <= '0;
            key_reg          <= 1'b0;
            interval_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_en)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.exec)
            begin
                tuple_reg        <= tuple_next;
                key_reg          <= key_next;
                interval_reg     <= interval_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.result_full = result_valid_reg;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> result_valid_reg)
        else $error("execute did not present a result");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear_en |=> (valid_reg == '0) && (tuple_reg == '0) && !key_reg)
        else $error("clear left state behind");

endmodule

@@ sv/histogram_sparse_delta_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// histogram_sparse_delta_accumulator_unit
// Histogram bin counters with tuple count, keyframe flag and interval id.
// ----------------------------------------------------------------------------
//  channel   valid          stall          word
//  -------   ------------   ------------   -------------------------
//  item      item_valid     item_stall     item   (hsda_pkg::item_t)
//  result    result_valid   result_stall   result (hsda_pkg::result_t)
//
//  Each word passes two states: capture reads the addressed counter from the
//  single-port counter memory, execute writes it back and forms the result.
//  Every word gives exactly one result word.
//  Reset clears all counters at once through per-bin valid bits; a clear
//  word does the same, so no clearing pass exists.
//  A new word is taken while the previous result still waits; execution
//  holds only if the result register is still occupied and stalled.
// ----------------------------------------------------------------------------
module histogram_sparse_delta_accumulator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hsda_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output hsda_pkg::result_t   result
);

    // command and status between sequencer and datapath
    hsda_pkg::ctrl_cmd_t  cmd;
    hsda_pkg::dp_status_t status;

    // sequencer: accept, then execute when the result register frees up
    hsda_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath: counter memory read-modify-write, scalars, result register
    hsda_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
